/* sv/fnsa_pkg.sv */
// Package of the frame number stream aligner.
// Holds the sequencer state type, register indexes and field widths.
// No dependencies.
package fnsa_pkg;

  localparam int NUM_W   = 32;
  localparam int TAG_W   = 16;
  localparam int ENTRY_W = NUM_W + TAG_W;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;
  localparam int MAX_RESULTS = 32;
  localparam int RES_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_STALE_GAP   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_WINDOW = 8'd1;

  localparam logic [CFG_DAT_W-1:0] STALE_GAP_RESET   = 8'd5;
  localparam logic [CFG_DAT_W-1:0] SKIP_WINDOW_RESET = 8'd4;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_BYPASS   = 9'b000000010,
    ST_AGE      = 9'b000000100,
    ST_ENQ      = 9'b000001000,
    ST_SCAN_RD  = 9'b000010000,
    ST_SCAN_CMP = 9'b000100000,
    ST_CHECK    = 9'b001000000,
    ST_EMIT_RD  = 9'b010000000,
    ST_EMIT_OUT = 9'b100000000
  } state_t;

endpackage

/* sv/fnsa_ram.sv */
// Generic single write port RAM with one registered read port.
// No dependencies.
module fnsa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/frame_number_stream_aligner_unit.sv */
// Frame number stream aligner: per-stream frame queues and frameset release.
// Depends on fnsa_pkg and fnsa_ram.
//
// Usage: an item (stream index, frame number, tag) is accepted at a clock
// edge where start is high and busy is low. Configuration writes go through
// the cfg_ channel (always ready); index 0 is stale_gap, index 1 is
// skip_window, other indexes are ignored. Write only while busy is low.
// Each released frame appears for one cycle with out_valid high, members
// of a frameset in descending stream order, out_last_in_set on the last.
// The receiver cannot stall; results are never held.
// Structure: one sequencer drives a single shared subtract/compare unit and
// one RAM read port. An item first passes through aging of every stream and
// queueing, then per release round through a head scan, a missing-stream
// check and the emission, plus a final scan (and a check when heads remain)
// that releases nothing. A frame with a stream index at or above NUM_STREAMS
// keeps busy high for one cycle and is passed straight out.
// Reset (synchronous, rst_n low) empties all queues, clears the flags and
// loads the register defaults; the frame store itself is not cleared.
module frame_number_stream_aligner_unit
  import fnsa_pkg::*;
#(
  parameter int NUM_STREAMS = 4,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_stream_index,
  input  logic [NUM_W-1:0]     in_frame_number,
  input  logic [TAG_W-1:0]     in_frame_tag,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output logic                 out_valid,
  output logic [1:0]           out_stream,
  output logic [NUM_W-1:0]     out_number,
  output logic [TAG_W-1:0]     out_tag,
  output logic                 out_last_in_set
);

  localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int GW = $clog2(NUM_STREAMS + 1);
  localparam int DEPTH = NUM_STREAMS * QUEUE_DEPTH;
  localparam int AW = $clog2(DEPTH);
  localparam logic [SW-1:0] K_LAST = SW'(NUM_STREAMS - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  state_t state_r, state_nxt;

  logic [SW-1:0]        k_r;
  logic [SW-1:0]        s_r;
  logic [1:0]           sraw_r;
  logic [NUM_W-1:0]     fn_r;
  logic [TAG_W-1:0]     tag_r;
  logic [PW-1:0]        head_r [NUM_STREAMS];
  logic [CW-1:0]        cnt_r  [NUM_STREAMS];
  logic [NUM_STREAMS-1:0] active_r;
  logic [NUM_STREAMS-1:0] seen_r;
  logic [NUM_W-1:0]     last_r [NUM_STREAMS];
  logic [NUM_W:0]       nexp_r [NUM_STREAMS];
  logic [CFG_DAT_W-1:0] gap_r;
  logic [CFG_DAT_W-1:0] skip_r;
  logic                 any_r;
  logic [NUM_W-1:0]     min_r;
  logic [GW-1:0]        grp_r;
  logic                 larger_r;
  logic                 rel_r;
  logic [RES_W-1:0]     n_r;

  // RAM
  logic               ram_we;
  logic [AW-1:0]      ram_wa;
  logic [AW-1:0]      ram_ra;
  logic [ENTRY_W-1:0] ram_rd;

  fnsa_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data ({fn_r, tag_r}),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  function automatic logic [PW-1:0] wrap_add(input logic [PW:0] a);
    logic [PW:0] q;
    q = (a >= (PW+1)'(QUEUE_DEPTH)) ? a - (PW+1)'(QUEUE_DEPTH) : a;
    return q[PW-1:0];
  endfunction

  // Enqueue pointer math for the arriving stream.
  logic          enq_full;
  logic [PW-1:0] enq_head;
  logic [CW-1:0] enq_cnt;
  logic [PW-1:0] enq_idx;

  always_comb begin
    enq_full = (cnt_r[s_r] >= CNT_FULL);
    enq_head = enq_full ? wrap_add({1'b0, head_r[s_r]} + (PW+1)'(1)) : head_r[s_r];
    enq_cnt  = enq_full ? CW'(QUEUE_DEPTH - 1) : cnt_r[s_r];
    enq_idx  = wrap_add((PW+1)'(enq_head) + (PW+1)'(enq_cnt));
  end

  assign ram_we = (state_r == ST_ENQ);
  assign ram_wa = AW'(s_r) * AW'(QUEUE_DEPTH) + AW'(enq_idx);
  assign ram_ra = AW'(k_r) * AW'(QUEUE_DEPTH) + AW'(head_r[k_r]);

  // Shared subtractor: aging distance or missing-stream distance.
  logic [NUM_W+1:0] sub_a, sub_b, diff;
  logic [NUM_W+1:0] adiff;
  logic             age_stale;
  logic             miss_hold;

  always_comb begin
    if (state_r == ST_AGE) begin
      sub_a = {2'b00, fn_r};
      sub_b = {2'b00, last_r[k_r]};
    end else begin
      sub_a = {2'b00, min_r};
      sub_b = {1'b0, nexp_r[k_r]};
    end
    diff  = sub_a - sub_b;
    adiff = diff[NUM_W+1] ? (~diff + (NUM_W+2)'(1)) : diff;
    age_stale = seen_r[k_r] && (adiff > (NUM_W+2)'(gap_r));
    miss_hold = seen_r[k_r] && active_r[k_r] && (cnt_r[k_r] == '0) &&
                !diff[NUM_W+1] && (diff <= (NUM_W+2)'(skip_r));
  end

  logic [NUM_W-1:0] head_num;
  logic             head_hit;
  assign head_num = ram_rd[ENTRY_W-1:TAG_W];
  assign head_hit = (cnt_r[k_r] != '0) && (head_num == min_r);

  logic [RES_W-1:0] n_sum;
  assign n_sum = n_r + RES_W'(grp_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (32'(in_stream_index) >= NUM_STREAMS) ? ST_BYPASS : ST_AGE;
        end
      end
      ST_BYPASS:   state_nxt = ST_IDLE;
      ST_AGE:      state_nxt = (k_r == K_LAST) ? ST_ENQ : ST_AGE;
      ST_ENQ:      state_nxt = ST_SCAN_RD;
      ST_SCAN_RD: begin
        if (cnt_r[k_r] != '0) begin
          state_nxt = ST_SCAN_CMP;
        end else if (k_r == K_LAST) begin
          state_nxt = any_r ? ST_CHECK : ST_IDLE;
        end
      end
      ST_SCAN_CMP: begin
        if (k_r == K_LAST) begin
          state_nxt = ST_CHECK;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_CHECK: begin
        if (larger_r || k_r == K_LAST || (rel_r && miss_hold)) begin
          if (rel_r && !(!larger_r && miss_hold) && n_sum <= RES_W'(MAX_RESULTS)) begin
            state_nxt = ST_EMIT_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT_RD: begin
        if (cnt_r[k_r] != '0) begin
          state_nxt = ST_EMIT_OUT;
        end else if (k_r == '0) begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_EMIT_OUT: state_nxt = (k_r == '0) ? ST_SCAN_RD : ST_EMIT_RD;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      k_r       <= '0;
      active_r  <= '0;
      seen_r    <= '0;
      gap_r     <= STALE_GAP_RESET;
      skip_r    <= SKIP_WINDOW_RESET;
      out_valid <= 1'b0;
      any_r     <= 1'b0;
      larger_r  <= 1'b0;
      rel_r     <= 1'b1;
      grp_r     <= '0;
      n_r       <= '0;
      for (int i = 0; i < NUM_STREAMS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
        last_r[i] <= '0;
        nexp_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == ST_BYPASS) || ((state_r == ST_EMIT_OUT) && head_hit);
      if (cfg_valid) begin
        case (cfg_index)
          REG_STALE_GAP:   gap_r  <= cfg_data;
          REG_SKIP_WINDOW: skip_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            sraw_r <= in_stream_index;
            s_r    <= SW'(in_stream_index);
            fn_r   <= in_frame_number;
            tag_r  <= in_frame_tag;
            k_r    <= '0;
            n_r    <= '0;
            any_r  <= 1'b0;
          end
        end
        ST_BYPASS: begin
          out_stream      <= sraw_r;
          out_number      <= fn_r;
          out_tag         <= tag_r;
          out_last_in_set <= 1'b1;
        end
        ST_AGE: begin
          if (age_stale) begin
            active_r[k_r] <= 1'b0;
            cnt_r[k_r]    <= '0;
          end
          k_r <= (k_r == K_LAST) ? '0 : k_r + SW'(1);
        end
        ST_ENQ: begin
          active_r[s_r] <= 1'b1;
          seen_r[s_r]   <= 1'b1;
          last_r[s_r]   <= fn_r;
          nexp_r[s_r]   <= {1'b0, fn_r} + (NUM_W+1)'(1);
          head_r[s_r]   <= enq_head;
          cnt_r[s_r]    <= enq_cnt + CW'(1);
          k_r           <= '0;
          any_r         <= 1'b0;
          larger_r      <= 1'b0;
          grp_r         <= '0;
        end
        ST_SCAN_RD: begin
          if (cnt_r[k_r] == '0) begin
            k_r <= (k_r == K_LAST) ? '0 : k_r + SW'(1);
            rel_r <= 1'b1;
          end
        end
        ST_SCAN_CMP: begin
          // Track minimum, its multiplicity and whether any head differs.
          if (!any_r || head_num < min_r) begin
            min_r    <= head_num;
            grp_r    <= GW'(1);
            larger_r <= any_r;
          end else if (head_num == min_r) begin
            grp_r <= grp_r + GW'(1);
          end else begin
            larger_r <= 1'b1;
          end
          any_r <= 1'b1;
          rel_r <= 1'b1;
          k_r   <= (k_r == K_LAST) ? '0 : k_r + SW'(1);
        end
        ST_CHECK: begin
          if (!larger_r && miss_hold) begin
            rel_r <= 1'b0;
          end
          if (state_nxt == ST_EMIT_RD) begin
            k_r <= K_LAST;
          end else if (state_nxt == ST_CHECK) begin
            k_r <= k_r + SW'(1);
          end
        end
        ST_EMIT_RD: begin
          if (cnt_r[k_r] == '0) begin
            if (k_r == '0) begin
              any_r    <= 1'b0;
              larger_r <= 1'b0;
              grp_r    <= '0;
            end else begin
              k_r <= k_r - SW'(1);
            end
          end
        end
        ST_EMIT_OUT: begin
          if (head_hit) begin
            out_stream      <= 2'(k_r);
            out_number      <= head_num;
            out_tag         <= ram_rd[TAG_W-1:0];
            out_last_in_set <= (grp_r == GW'(1));
            n_r             <= n_r + RES_W'(1);
            head_r[k_r]     <= wrap_add({1'b0, head_r[k_r]} + (PW+1)'(1));
            cnt_r[k_r]      <= cnt_r[k_r] - CW'(1);
          end
          if (k_r == '0) begin
            any_r    <= 1'b0;
            larger_r <= 1'b0;
            grp_r    <= '0;
          end else begin
            if (head_hit) begin
              grp_r <= grp_r - GW'(1);
            end
            k_r <= k_r - SW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

endmodule
